// ----- hw/rtl/tsnm_pkg.sv -----
package tsnm_pkg;

  localparam int CMD_W  = 2;
  localparam int DIM_W  = 16;
  localparam int DLT_W  = 17;
  localparam int SQ_W   = 32;
  localparam int DIST_W = 33;
  localparam int IDX_W  = 6;
  localparam int CFG_AW = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_TOLERANCE = 8'd0;
  localparam logic [CFG_AW-1:0] CFG_FLAG_DIFF = 8'd1;

  localparam logic [DIM_W-1:0] TOLERANCE_RST = 16'd100;
  localparam logic [DIM_W-1:0] FLAG_DIFF_RST = 16'd200;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic issue;
    logic issue_side;
    logic finish;
  } tsnm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } tsnm_sts_t;

endpackage

// ----- hw/rtl/two_sided_nearest_match_table_unit.sv -----
// Two-sided nearest match table.
// Input channel (in_valid / in_stall) carries a command: clear, load or query.
// A transfer happens at a clock edge with valid high and stall low.
// Clear and load give no result; a load into a full table
// is dropped. Loads mark an entry flagged when its left/right sides differ by
// more than flag_diff on either axis.
// A query scans the loaded entries, left side then right side, one side per
// cycle through a single memory read port and a multiply/compare pipeline:
// in_stall is high through the scan, the drain states and the done state;
// out_valid rises at the edge that ends that stretch, and the next command is
// taken the cycle after.
// The result sits in an output register; clear and load are accepted while it
// waits. If out_stall holds a previous result, a finished query waits for it.
// cfg_ writes (index 0 tolerance, 1 flag_diff) are always ready; write only
// while idle. Other indexes are ignored.
// Reset (rst_n low, synchronous) empties the table, restores tolerance 100
// and flag_diff 200 and drops any pending result. Table contents have no reset.
module two_sided_nearest_match_table_unit
  import tsnm_pkg::*;
#(
  parameter int ENTRY_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [DIM_W-1:0]        in_a_left,
  input  logic [DIM_W-1:0]        in_b_left,
  input  logic [DIM_W-1:0]        in_a_right,
  input  logic [DIM_W-1:0]        in_b_right,
  input  logic [DIM_W-1:0]        in_measured_a,
  input  logic [DIM_W-1:0]        in_measured_b,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_AW-1:0]       cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic                    out_matched,
  output logic [IDX_W-1:0]        out_best_index,
  output logic                    out_side,
  output logic signed [DLT_W-1:0] out_delta_a,
  output logic signed [DLT_W-1:0] out_delta_b,
  output logic [DIST_W-1:0]       out_distance_sq
);

  localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int CW = $clog2(ENTRY_DEPTH + 1);

  tsnm_cmd_t     cmd;
  tsnm_sts_t     sts;
  logic [AW-1:0] scan_addr;

  tsnm_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd),
    .scan_addr  (scan_addr)
  );

  tsnm_dpath #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .scan_addr       (scan_addr),
    .sts             (sts),
    .in_a_left       (in_a_left),
    .in_b_left       (in_b_left),
    .in_a_right      (in_a_right),
    .in_b_right      (in_b_right),
    .in_measured_a   (in_measured_a),
    .in_measured_b   (in_measured_b),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cfg_ready       (cfg_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_matched     (out_matched),
    .out_best_index  (out_best_index),
    .out_side        (out_side),
    .out_delta_a     (out_delta_a),
    .out_delta_b     (out_delta_b),
    .out_distance_sq (out_distance_sq)
  );

endmodule

// ----- hw/rtl/tsnm_ctrl.sv -----
module tsnm_ctrl
  import tsnm_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_stall,
  input  tsnm_sts_t        sts,
  output tsnm_cmd_t        cmd,
  output logic [AW-1:0]    scan_addr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // last drain count; by its end the last issued read has reached the best-candidate registers
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          side_r, side_nxt;
  logic [1:0]    drain_r, drain_nxt;
  logic          accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign scan_addr = addr_r;

  always_comb begin
    cmd            = '0;
    cmd.load       = accept && (in_command == CMD_LOAD);
    cmd.clear      = accept && (in_command == CMD_CLEAR);
    cmd.start      = accept && (in_command == CMD_QUERY);
    cmd.issue      = (state_r == ST_SCAN);
    cmd.issue_side = side_r;
    cmd.finish     = (state_r == ST_DONE) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    side_nxt  = side_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt  = '0;
        side_nxt  = 1'b0;
        drain_nxt = '0;
        if (accept && (in_command == CMD_QUERY)) begin
          state_nxt = sts.count_zero ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        side_nxt = ~side_r;
        if (side_r) begin
          if (sts.scan_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == DRAIN_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
      side_r  <= 1'b0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      side_r  <= side_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ----- hw/rtl/tsnm_dpath.sv -----
module tsnm_dpath
  import tsnm_pkg::*;
#(
  parameter int ENTRY_DEPTH = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsnm_cmd_t               cmd,
  input  logic [AW-1:0]           scan_addr,
  output tsnm_sts_t               sts,
  input  logic [DIM_W-1:0]        in_a_left,
  input  logic [DIM_W-1:0]        in_b_left,
  input  logic [DIM_W-1:0]        in_a_right,
  input  logic [DIM_W-1:0]        in_b_right,
  input  logic [DIM_W-1:0]        in_measured_a,
  input  logic [DIM_W-1:0]        in_measured_b,
  input  logic                    cfg_valid,
  input  logic [CFG_AW-1:0]       cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  output logic                    cfg_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic                    out_matched,
  output logic [IDX_W-1:0]        out_best_index,
  output logic                    out_side,
  output logic signed [DLT_W-1:0] out_delta_a,
  output logic signed [DLT_W-1:0] out_delta_b,
  output logic [DIST_W-1:0]       out_distance_sq
);

  localparam int BW    = (AW > IDX_W) ? AW : IDX_W;
  localparam int WORD_W = 4 * DIM_W + 1;

  // word: {flag, b_right, a_right, b_left, a_left}
  logic [WORD_W-1:0] mem [ENTRY_DEPTH];

  logic [DIM_W-1:0] tol_r, fdiff_r;
  logic [CW-1:0]    count_r;
  logic [DIM_W-1:0] meas_a_r, meas_b_r;

  // config
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOLERANCE_RST;
      fdiff_r <= FLAG_DIFF_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TOLERANCE) tol_r <= cfg_data;
      if (cfg_index == CFG_FLAG_DIFF) fdiff_r <= cfg_data;
    end
  end

  // load path
  logic [DIM_W-1:0] diff_a, diff_b;
  logic             load_flag, table_full;

  assign diff_a     = (in_a_left >= in_a_right) ? in_a_left - in_a_right
                                                : in_a_right - in_a_left;
  assign diff_b     = (in_b_left >= in_b_right) ? in_b_left - in_b_right
                                                : in_b_right - in_b_left;
  assign load_flag  = (diff_a > fdiff_r) || (diff_b > fdiff_r);
  assign table_full = (count_r == CW'(ENTRY_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.load && !table_full) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !table_full) begin
      mem[count_r[AW-1:0]] <= {load_flag, in_b_right, in_a_right, in_b_left, in_a_left};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      meas_a_r <= in_measured_a;
      meas_b_r <= in_measured_b;
    end
  end

  // stage 1: registered read
  logic [WORD_W-1:0] rd_q;
  logic              p1_valid_r, p1_side_r;
  logic [AW-1:0]     p1_addr_r;

  always_ff @(posedge clk) begin
    rd_q      <= mem[scan_addr];
    p1_side_r <= cmd.issue_side;
    p1_addr_r <= scan_addr;
  end

  // stage 2: deltas and tolerance check
  logic [DIM_W-1:0]        sel_a, sel_b, mag_a, mag_b;
  logic signed [DLT_W-1:0] da, db;
  logic [DLT_W-1:0]        neg_a, neg_b;
  logic                    p1_within;

  assign sel_a = p1_side_r ? rd_q[3*DIM_W-1:2*DIM_W] : rd_q[DIM_W-1:0];
  assign sel_b = p1_side_r ? rd_q[4*DIM_W-1:3*DIM_W] : rd_q[2*DIM_W-1:DIM_W];
  assign da    = signed'({1'b0, sel_a}) - signed'({1'b0, meas_a_r});
  assign db    = signed'({1'b0, sel_b}) - signed'({1'b0, meas_b_r});
  assign neg_a = -da;
  assign neg_b = -db;
  assign mag_a = da[DLT_W-1] ? neg_a[DIM_W-1:0] : da[DIM_W-1:0];
  assign mag_b = db[DLT_W-1] ? neg_b[DIM_W-1:0] : db[DIM_W-1:0];
  assign p1_within = (mag_a <= tol_r) && (mag_b <= tol_r);

  logic                    p2_valid_r, p2_side_r, p2_within_r;
  logic [AW-1:0]           p2_addr_r;
  logic signed [DLT_W-1:0] p2_da_r, p2_db_r;
  logic [DIM_W-1:0]        p2_mag_a_r, p2_mag_b_r;

  always_ff @(posedge clk) begin
    p2_side_r   <= p1_side_r;
    p2_within_r <= p1_within;
    p2_addr_r   <= p1_addr_r;
    p2_da_r     <= da;
    p2_db_r     <= db;
    p2_mag_a_r  <= mag_a;
    p2_mag_b_r  <= mag_b;
  end

  // stage 3: squares
  logic                    p3_valid_r, p3_side_r, p3_within_r;
  logic [AW-1:0]           p3_addr_r;
  logic signed [DLT_W-1:0] p3_da_r, p3_db_r;
  logic [SQ_W-1:0]         p3_sq_a_r, p3_sq_b_r;

  always_ff @(posedge clk) begin
    p3_side_r   <= p2_side_r;
    p3_within_r <= p2_within_r;
    p3_addr_r   <= p2_addr_r;
    p3_da_r     <= p2_da_r;
    p3_db_r     <= p2_db_r;
    p3_sq_a_r   <= SQ_W'(p2_mag_a_r) * SQ_W'(p2_mag_a_r);
    p3_sq_b_r   <= SQ_W'(p2_mag_b_r) * SQ_W'(p2_mag_b_r);
  end

  // flagged entries never become candidates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= cmd.issue;
      p2_valid_r <= p1_valid_r && !rd_q[WORD_W-1];
      p3_valid_r <= p2_valid_r;
    end
  end

  // stage 4: best-candidate update
  logic [DIST_W-1:0]       cand_d;
  logic                    take, closer;
  logic                    found_r, matched_r, best_side_r;
  logic [BW-1:0]           best_idx_r;
  logic signed [DLT_W-1:0] best_da_r, best_db_r;
  logic [DIST_W-1:0]       best_d_r;

  assign cand_d = DIST_W'(p3_sq_a_r) + DIST_W'(p3_sq_b_r);
  assign closer = cand_d < best_d_r;

  always_comb begin
    if (matched_r) begin
      take = p3_within_r && closer;
    end else begin
      take = p3_within_r || !found_r || closer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      matched_r <= 1'b0;
    end else if (cmd.start) begin
      found_r   <= 1'b0;
      matched_r <= 1'b0;
    end else if (p3_valid_r && take) begin
      found_r <= 1'b1;
      if (p3_within_r) matched_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_idx_r  <= '0;
      best_side_r <= 1'b0;
      best_da_r   <= '0;
      best_db_r   <= '0;
      best_d_r    <= '0;
    end else if (p3_valid_r && take) begin
      best_idx_r  <= BW'(p3_addr_r);
      best_side_r <= p3_side_r;
      best_da_r   <= p3_da_r;
      best_db_r   <= p3_db_r;
      best_d_r    <= cand_d;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found       <= found_r;
      out_matched     <= matched_r;
      out_best_index  <= best_idx_r[IDX_W-1:0];
      out_side        <= best_side_r;
      out_delta_a     <= best_da_r;
      out_delta_b     <= best_db_r;
      out_distance_sq <= best_d_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.count_zero = (count_r == '0);
  assign sts.scan_last  = ((CW'(scan_addr) + CW'(1)) == count_r);

endmodule
